>>> src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command kinds passed from the front end to the back end, action codes of
// the input beat and the character constants of the console.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // action field of an input beat
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // decoded command kinds
  localparam logic [2:0] OP_PRINT   = 3'd0;
  localparam logic [2:0] OP_NEWLINE = 3'd1;
  localparam logic [2:0] OP_IGNORE  = 3'd2;  // put of a code that prints nothing
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_NONE    = 3'd5;  // unused action, read out of range

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  BLANK_CHAR   = 8'h20;
  localparam logic [7:0]  PRINT_LO     = 8'h20;
  localparam logic [7:0]  PRINT_HI     = 8'h7F;
  localparam logic [7:0]  ATTR_RESET   = 8'h0F;
  localparam logic [15:0] CELL_RESET   = 16'h0F20;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] code;
  } tcw_cmd_t;

endpackage

`default_nettype wire

>>> src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> src/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input decode and command queue
// Classifies each input beat into a command kind and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int CELLS = COLUMNS * ROWS,
  localparam int AW = $clog2(CELLS)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            hold,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_action,
  input  wire logic [7:0]      in_char_code,
  input  wire logic [10:0]     in_cell_index,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output tcw_pkg::tcw_cmd_t    cmd,
  output logic      [AW-1:0]   cmd_addr
);

  import tcw_pkg::*;

  tcw_cmd_t    cmd_q_r  [2];
  logic [AW-1:0] addr_q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        push, pop;
  tcw_cmd_t    dec_cmd;

  always_comb begin
    dec_cmd.code = in_char_code;
    unique case (in_action)
      ACT_PUT: begin
        if (in_char_code == NEWLINE_CODE) begin
          dec_cmd.kind = OP_NEWLINE;
        end else if (in_char_code >= PRINT_LO && in_char_code <= PRINT_HI) begin
          dec_cmd.kind = OP_PRINT;
        end else begin
          dec_cmd.kind = OP_IGNORE;
        end
      end
      ACT_CLEAR: dec_cmd.kind = OP_CLEAR;
      ACT_READ: begin
        dec_cmd.kind = (32'(in_cell_index) < 32'(CELLS)) ? OP_READ : OP_NONE;
      end
      default: dec_cmd.kind = OP_NONE;
    endcase
  end

  assign in_ready  = (count_r != 2'd2) && !hold;
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = cmd_q_r[rd_ptr_r];
  assign cmd_addr  = addr_q_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r]  <= dec_cmd;
      addr_q_r[wr_ptr_r] <= AW'(in_cell_index);
    end
  end

endmodule

`default_nettype wire

>>> src/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: command execution
// Owns the cell RAM, the cursor and the result register; runs the reset
// fill, clear, scroll and put/read sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int CELLS = COLUMNS * ROWS,
  localparam int AW = $clog2(CELLS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         cfg_attr,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire tcw_pkg::tcw_cmd_t  cmd,
  input  wire logic [AW-1:0]      cmd_addr,
  output logic                    init_busy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [10:0]        out_cursor_position,
  output logic      [15:0]        out_cell_value,
  output logic                    out_scrolled
);

  import tcw_pkg::*;

  localparam int CW   = $clog2(CELLS + 1);
  localparam int COLW = $clog2(COLUMNS);
  localparam int MOVE = CELLS - COLUMNS;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_PUT    = 3'd6;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [CW-1:0]   row_base_r, row_base_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  tcw_cmd_t        op_r, op_nxt;
  logic            scroll_flag_r, scroll_flag_nxt;
  logic            wb_valid_r, wb_valid_nxt;
  logic [AW-1:0]   wb_addr_r, wb_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [10:0]     out_cursor_r, out_cursor_nxt;
  logic [15:0]     out_cell_r, out_cell_nxt;
  logic            out_scrolled_r, out_scrolled_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [15:0]     wr_data, rd_data;
  logic [15:0]     blank;
  logic            out_free;
  logic            last_cell;

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cells (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign blank     = {cfg_attr, BLANK_CHAR};
  assign out_free  = !out_valid_r || out_ready;
  assign last_cell = (cnt_r == AW'(CELLS - 1));

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    cursor_nxt       = cursor_r;
    row_base_nxt     = row_base_r;
    col_nxt          = col_r;
    op_nxt           = op_r;
    scroll_flag_nxt  = scroll_flag_r;
    wb_valid_nxt     = 1'b0;
    wb_addr_nxt      = wb_addr_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_cursor_nxt   = out_cursor_r;
    out_cell_nxt     = out_cell_r;
    out_scrolled_nxt = out_scrolled_r;
    cmd_ready        = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = cnt_r;
    wr_data          = blank;
    rd_addr          = AW'(32'(cnt_r) + COLUMNS);

    // write back of a row copy read in the previous cycle
    if (wb_valid_r) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr_r;
      wr_data = rd_data;
    end

    unique case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = CELL_RESET;
        if (last_cell) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        cmd_ready = out_free;
        rd_addr   = cmd_addr;
        if (cmd_valid && out_free) begin
          op_nxt          = cmd;
          scroll_flag_nxt = 1'b0;
          cnt_nxt         = '0;
          unique case (cmd.kind)
            OP_READ:  state_nxt = S_READ;
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_PRINT, OP_NEWLINE, OP_IGNORE: begin
              state_nxt = (cursor_r == CW'(CELLS)) ? S_SCROLL : S_PUT;
            end
            default:  state_nxt = S_PUT;
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt    = 1'b1;
        out_cursor_nxt   = 11'(cursor_r);
        out_cell_nxt     = rd_data;
        out_scrolled_nxt = 1'b0;
        state_nxt        = S_IDLE;
      end
      S_SCROLL: begin
        if (cnt_r == AW'(MOVE)) begin
          state_nxt = S_BLANK;
        end else begin
          wb_valid_nxt = 1'b1;
          wb_addr_nxt  = cnt_r;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      S_BLANK: begin
        wr_en = 1'b1;
        if (last_cell) begin
          cursor_nxt      = CW'(MOVE);
          row_base_nxt    = CW'(MOVE);
          col_nxt         = '0;
          scroll_flag_nxt = 1'b1;
          state_nxt       = S_PUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CLEAR: begin
        wr_en = 1'b1;
        if (last_cell) begin
          cursor_nxt       = '0;
          row_base_nxt     = '0;
          col_nxt          = '0;
          out_valid_nxt    = 1'b1;
          out_cursor_nxt   = '0;
          out_cell_nxt     = '0;
          out_scrolled_nxt = 1'b0;
          state_nxt        = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PUT: begin
        unique case (op_r.kind)
          OP_PRINT: begin
            wr_en      = 1'b1;
            wr_addr    = AW'(cursor_r);
            wr_data    = {cfg_attr, op_r.code};
            cursor_nxt = cursor_r + 1'b1;
            if (col_r == COLW'(COLUMNS - 1)) begin
              col_nxt      = '0;
              row_base_nxt = row_base_r + CW'(COLUMNS);
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
          OP_NEWLINE: begin
            cursor_nxt   = row_base_r + CW'(COLUMNS);
            row_base_nxt = row_base_r + CW'(COLUMNS);
            col_nxt      = '0;
          end
          default: begin
          end
        endcase
        out_valid_nxt    = 1'b1;
        out_cursor_nxt   = 11'(cursor_nxt);
        out_cell_nxt     = '0;
        out_scrolled_nxt = scroll_flag_r;
        state_nxt        = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      cnt_r         <= '0;
      cursor_r      <= '0;
      row_base_r    <= '0;
      col_r         <= '0;
      scroll_flag_r <= 1'b0;
      wb_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      cursor_r      <= cursor_nxt;
      row_base_r    <= row_base_nxt;
      col_r         <= col_nxt;
      scroll_flag_r <= scroll_flag_nxt;
      wb_valid_r    <= wb_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    wb_addr_r      <= wb_addr_nxt;
    out_cursor_r   <= out_cursor_nxt;
    out_cell_r     <= out_cell_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  assign init_busy           = (state_r == S_INIT);
  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_cursor_r;
  assign out_cell_value      = out_cell_r;
  assign out_scrolled        = out_scrolled_r;

endmodule

`default_nettype wire

>>> src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: teletype style text console, COLUMNS x ROWS cells
// Input beat: action (put / clear / read), char_code, cell_index, valid/ready.
// Result beat: cursor_position, cell_value, scrolled; one per input beat,
// valid/ready, held in an output register until taken.
// cfg_wr_en with cfg_text_attribute loads the attribute byte (reset 0x0F)
// used for printed and blanked cells; write it only while the block is idle.
// Each beat is queued, then executed, and its result registered for output.
// The sequencer runs one command at a time on the single RAM write port:
//   put (print, newline, ignored code) and read: put or read state, then idle
//   put with the cursor past the end: scroll and blank states first, then put
//   clear: clear state, one cell written per cycle
// A two-entry command queue sits between decode and execution, so input
// beats keep being taken while a long sequence or a stalled result is
// pending. When the receiver holds out_ready low, execution waits for the
// output register; the queue then fills and in_ready drops.
// After reset the RAM is filled with blank cells (0x0F20); in_ready stays
// low during the fill; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_text_attribute,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [10:0] in_cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [10:0] out_cursor_position,
  output logic      [15:0] out_cell_value,
  output logic             out_scrolled
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int MOVE  = CELLS - COLUMNS;

  logic [7:0]    text_attribute_r;
  logic          init_busy;
  logic          cmd_valid, cmd_ready;
  tcw_cmd_t      cmd;
  logic [AW-1:0] cmd_addr;

  // attribute register, loaded whenever the write enable is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attribute_r <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      text_attribute_r <= cfg_text_attribute;
    end
  end

  // decode and queue; holds off input during the reset fill
  tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .hold          (init_busy),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .cmd_addr      (cmd_addr)
  );

  // execution: cell RAM, cursor, scroll/clear sequencer, result register
  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_attr            (text_attribute_r),
    .cmd_valid           (cmd_valid),
    .cmd_ready           (cmd_ready),
    .cmd                 (cmd),
    .cmd_addr            (cmd_addr),
    .init_busy           (init_busy),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value),
    .out_scrolled        (out_scrolled)
  );

  // a scroll lands the cursor on the last row: start, one past, or past end
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      (out_cursor_position == 11'(MOVE)) ||
      (out_cursor_position == 11'(MOVE + 1)) ||
      (out_cursor_position == 11'(CELLS)))
    else $error("scroll result with unexpected cursor");

  // only put beats scroll, and they never carry cell data
  a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> out_cell_value == 16'h0000)
    else $error("scroll result carries cell data");

  // the reset fill keeps input closed right after reset
  a_init_holds_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during reset fill");

endmodule

`default_nettype wire

>>> tb/text_console_writer_test.sv
// ----------------------------------------------------------------------------
// text_console_writer_test: self-checking bench for the text console writer
// Drives put / clear / read beats through the valid/ready input channel and
// checks every result beat against a shadow copy of the cell store, cursor
// and text attribute. Covers the blank screen after reset, every character
// class, scroll from past the end, clear, reads outside the screen and the
// unused action. It also covers a long result stall and a long random text
// stream written under several attribute settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROW_COUNT = 25;
  localparam int CELL_COUNT = COLS * ROW_COUNT;
  localparam int LAST_ROW_START = CELL_COUNT - COLS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;      // no action, result only
  localparam int RANDOM_BEATS = 1800;
  localparam int TEXT_PHASES = 6;
  localparam longint LIMIT_NS = 100_000_000;     // far above the slowest run

  // one result beat, in port order
  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
    logic        scrolled;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_text_attribute;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_char_code;
  logic [10:0] in_cell_index;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] out_cursor_position;
  logic [15:0] out_cell_value;
  logic        out_scrolled;

  // shadow console: what the block should hold after every accepted beat
  logic [15:0] shadow_cells [CELL_COUNT];
  int          shadow_cursor;
  logic [7:0]  shadow_attr;

  console_result_t pending_results [$];

  // sender / receiver behavior, set per test
  bit src_idle;
  bit sink_idle;
  int hold_off_len;        // picked up by the receiver, counted down there
  int longest_hold_off;

  int mismatch_count;
  int results_seen;
  int put_count, clear_count, read_count, unused_count, scroll_count;
  int attr_writes;

  text_console_writer #(
    .COLUMNS (COLS),
    .ROWS    (ROW_COUNT)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_text_attribute  (cfg_text_attribute),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_position (out_cursor_position),
    .out_cell_value      (out_cell_value),
    .out_scrolled        (out_scrolled)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Console prediction: apply one accepted beat to the shadow state and
  // return the result beat it must produce.
  // --------------------------------------------------------------------------
  function automatic console_result_t console_step(input logic [1:0] act,
                                                   input logic [7:0] code,
                                                   input logic [10:0] idx);
    console_result_t res;
    logic [15:0] blank;
    res = '0;
    blank = {shadow_attr, BLANK_CHAR};
    case (act)
      ACT_PUT: begin
        // cursor parked past the end: make room first, then handle the code
        if (shadow_cursor >= CELL_COUNT) begin
          for (int i = 0; i < LAST_ROW_START; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
          for (int i = LAST_ROW_START; i < CELL_COUNT; i++)
            shadow_cells[i] = blank;
          shadow_cursor = LAST_ROW_START;
          res.scrolled = 1'b1;
          scroll_count++;
        end
        if (code == NEWLINE_CODE) begin
          shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
          if (shadow_cursor > CELL_COUNT)
            shadow_cursor = CELL_COUNT;
        end else if (code >= PRINT_LO && code <= PRINT_HI) begin
          shadow_cells[shadow_cursor] = {shadow_attr, code};
          shadow_cursor++;
        end
        // control codes and the upper half print nothing
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          shadow_cells[i] = blank;
        shadow_cursor = 0;
      end
      ACT_READ: begin
        if (idx < CELL_COUNT)
          res.cell_value = shadow_cells[idx];
      end
      default: ;
    endcase
    res.cursor_position = shadow_cursor[10:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // gap lengths: mostly short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(1, 3);
    else if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one input beat. Valid goes up at a falling edge and stays up
  // until the rising edge that takes the beat; the expectation is queued
  // at that edge. Valid is left high so the next beat can follow directly.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] act, input logic [7:0] code,
                           input logic [10:0] idx);
    int gap;
    gap = (src_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(console_step(act, code, idx));
    case (act)
      ACT_PUT:   put_count++;
      ACT_CLEAR: clear_count++;
      ACT_READ:  read_count++;
      default:   unused_count++;
    endcase
  endtask

  // drop valid and wait until every expected result beat has been taken
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // only called with nothing in flight; shadow follows once the register is loaded
  task automatic set_text_attribute(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en          <= 1'b1;
    cfg_text_attribute <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_attr = value;
    attr_writes++;
  endtask

  // one beat of a text stream: mostly printable text, some newlines and
  // dead codes, unused actions, reads that favor the cell just written, rare clears
  task automatic random_text_beat(input bit allow_clear);
    int r;
    logic [7:0]  code;
    logic [10:0] idx;
    r = $urandom_range(0, 999);
    code = 8'($urandom_range(0, 255));
    idx = 11'($urandom_range(0, 2047));
    if (allow_clear && r < 15) begin
      send_beat(ACT_CLEAR, code, idx);
    end else if (r < 35) begin
      send_beat(ACT_UNUSED, code, idx);
    end else if (r < 190) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        idx = (shadow_cursor == 0) ? 11'd0 : 11'(shadow_cursor - 1);
      else if (r < 90)
        idx = 11'($urandom_range(0, CELL_COUNT - 1));
      else
        idx = 11'($urandom_range(CELL_COUNT, 2047));   // off the screen
      send_beat(ACT_READ, code, idx);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 6)
        code = NEWLINE_CODE;
      else if (r < 12)
        code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                    : 8'($urandom_range(128, 255));
      else
        code = 8'($urandom_range(PRINT_LO, PRINT_HI));
      send_beat(ACT_PUT, code, idx);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // blank screen after the fill pass, reads off the screen, unused action
  task automatic test_reset_contents();
    send_beat(ACT_READ, 8'h00, 11'd0);
    send_beat(ACT_READ, 8'hFF, 11'(CELL_COUNT - 1));
    send_beat(ACT_READ, 8'h00, 11'(CELL_COUNT));
    send_beat(ACT_READ, 8'h00, 11'h7FF);
    send_beat(ACT_UNUSED, 8'hFF, 11'h7FF);
  endtask

  // printable range edges, control codes, upper half, newline
  task automatic test_put_codes();
    send_beat(ACT_PUT, PRINT_LO, 11'h7FF);
    send_beat(ACT_PUT, PRINT_HI, 11'd0);
    send_beat(ACT_PUT, 8'h41, 11'd0);
    send_beat(ACT_PUT, 8'h00, 11'd0);
    send_beat(ACT_PUT, 8'h1F, 11'd0);
    send_beat(ACT_PUT, 8'h80, 11'd0);
    send_beat(ACT_PUT, 8'hFF, 11'd0);
    send_beat(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_beat(ACT_PUT, 8'h7E, 11'd0);
    send_beat(ACT_READ, 8'h00, 11'd0);
    send_beat(ACT_READ, 8'h00, 11'd2);
    send_beat(ACT_READ, 8'h00, 11'd3);
    send_beat(ACT_READ, 8'h00, 11'(COLS));
  endtask

  // clear with the all-ones attribute
  task automatic test_clear();
    wait_idle();
    set_text_attribute(8'hFF);
    send_beat(ACT_PUT, 8'h41, 11'd0);
    send_beat(ACT_CLEAR, 8'h00, 11'd0);
    send_beat(ACT_READ, 8'h00, 11'd0);
    send_beat(ACT_READ, 8'h00, 11'(CELL_COUNT - 1));
  endtask

  // newline from the last row parks the cursor past the end; the next put
  // scrolls, whether its code prints, prints nothing or is a newline
  task automatic test_scroll();
    wait_idle();
    set_text_attribute(8'h00);
    send_beat(ACT_CLEAR, 8'h00, 11'd0);
    repeat (ROW_COUNT) send_beat(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_beat(ACT_PUT, 8'h00, 11'd0);
    send_beat(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_beat(ACT_PUT, 8'h5A, 11'd0);
    send_beat(ACT_READ, 8'h00, 11'(LAST_ROW_START));
    send_beat(ACT_READ, 8'h00, 11'(LAST_ROW_START - COLS));
    send_beat(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_beat(ACT_PUT, NEWLINE_CODE, 11'd0);
    send_beat(ACT_READ, 8'h00, 11'(LAST_ROW_START - COLS));
    send_beat(ACT_READ, 8'h00, 11'(CELL_COUNT - 1));
  endtask

  // receiver holds off for a long stretch while beats keep coming, so the
  // command queue fills and in_ready drops; then the sender waits for all
  task automatic test_result_stall();
    wait_idle();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    hold_off_len = 150;
    repeat (24) random_text_beat(1'b0);
    wait_idle();
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // long text stream in phases, attribute changed between phases
  task automatic test_random_text();
    int per_phase;
    per_phase = RANDOM_BEATS / TEXT_PHASES;
    for (int phase = 0; phase < TEXT_PHASES; phase++) begin
      wait_idle();
      if (phase == 0)
        set_text_attribute(8'h00);
      else if (phase == 1)
        set_text_attribute(8'hFF);
      else
        set_text_attribute(8'($urandom_range(0, 255)));
      // phase 2 runs flat out on both sides, phase 4 never stalls results
      src_idle = (phase != 2);
      sink_idle = (phase != 2 && phase != 4);
      for (int n = 0; n < per_phase; n++) begin
        if (phase == 3 && n == per_phase / 2)
          hold_off_len = $urandom_range(60, 150);
        random_text_beat(1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: out_ready changes at falling edges. Random stalls when
  // sink_idle is set; a requested hold-off is counted down here in cycles.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        stall_left = hold_off_len;
        if (hold_off_len > longest_hold_off)
          longest_hold_off = hold_off_len;
        hold_off_len = 0;
      end else if (stall_left == 0 && sink_idle && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result check: every taken result beat against the oldest expectation
  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (cursor %0d)",
                                  out_cursor_position));
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_cursor_position !== want.cursor_position)
          report_mismatch($sformatf("result %0d cursor_position got %0d want %0d",
                                    results_seen, out_cursor_position,
                                    want.cursor_position));
        if (out_cell_value !== want.cell_value)
          report_mismatch($sformatf("result %0d cell_value got %04h want %04h",
                                    results_seen, out_cell_value, want.cell_value));
        if (out_scrolled !== want.scrolled)
          report_mismatch($sformatf("result %0d scrolled got %0b want %0b",
                                    results_seen, out_scrolled, want.scrolled));
      end
    end
  end

  // hard stop
  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d result beats still expected", pending_results.size());
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_text_attribute = ATTR_RESET;
    in_valid = 1'b0;
    in_action = ACT_PUT;
    in_char_code = 8'h00;
    in_cell_index = 11'd0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    hold_off_len = 0;
    longest_hold_off = 0;
    shadow_attr = ATTR_RESET;
    shadow_cursor = 0;
    for (int i = 0; i < CELL_COUNT; i++)
      shadow_cells[i] = CELL_RESET;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // the block fills its RAM after reset; in_ready holds beats off until done
    test_reset_contents();
    test_put_codes();
    test_clear();
    test_scroll();
    test_result_stall();
    test_random_text();

    wait_idle();
    repeat (8) @(posedge clk);

    $display("covered %0d puts, %0d clears, %0d reads, %0d unused-action beats; %0d scrolls",
             put_count, clear_count, read_count, unused_count, scroll_count);
    $display("%0d results checked, %0d attribute writes, longest result stall %0d cycles",
             results_seen, attr_writes, longest_hold_off);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> text_console_writer.f
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_back.sv
src/text_console_writer.sv
tb/text_console_writer_test.sv
